@@ rtl/mevb_pkg.sv @@
// Package for the MIDI event byte encoder.
// Holds the item, job and result types, the opcodes and the status constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mevb_pkg;

  localparam int CHANNELS = 16;
  localparam int VLQ_MAX  = 4;
  localparam int BODY_MAX = 6;

  localparam logic [2:0] OP_NOTE_OFF = 3'd0;
  localparam logic [2:0] OP_NOTE_ON  = 3'd1;
  localparam logic [2:0] OP_PATCH    = 3'd2;
  localparam logic [2:0] OP_CONTROL  = 3'd3;
  localparam logic [2:0] OP_BEND     = 3'd4;
  localparam logic [2:0] OP_TEMPO    = 3'd5;
  localparam logic [2:0] OP_END      = 3'd6;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PATCH    = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [7:0] META_BYTE   = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] NO_STATUS   = 8'hFF;
  localparam logic [6:0] REL_VEL_RST = 7'd64;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [27:0] delta_ticks;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [13:0] bend_amount;
    logic [23:0] tempo_us;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                last_byte;
    logic [CHANNELS-1:0] used_channels;
  } out_item_t;

  typedef struct packed {
    logic [VLQ_MAX-1:0][7:0]  vlq;
    logic [2:0]               vlq_cnt;
    logic [BODY_MAX-1:0][7:0] body;
    logic [2:0]               body_cnt;
    logic [CHANNELS-1:0]      mask;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage
`default_nettype wire

@@ rtl/mevb_front.sv @@
// Front end of the encoder: takes an event item, tracks running status and the
// channel mask, and builds the byte job for the back end. Uses mevb_pkg.
`default_nettype none
module mevb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [6:0]        cfg_wdata,
  input  wire logic              accept,
  input  wire mevb_pkg::in_item_t item,
  output logic                   push,
  output mevb_pkg::job_t         job
);
  import mevb_pkg::*;

  logic [7:0]          rs_r, rs_nxt;
  logic [CHANNELS-1:0] mask_r, mask_nxt;
  logic [6:0]          relvel_r, relvel_nxt;

  logic [7:0]  status;
  logic        chan_op;
  logic        emit_status;
  logic [6:0]  d2e;
  logic [1:0][7:0] dat;
  logic [2:0]  dcnt;
  logic [27:0] d;

  always_comb begin
    d = item.delta_ticks;
    job = '0;
    if (d >= 28'd2097152) begin
      job.vlq_cnt = 3'd4;
      job.vlq[0] = {1'b1, d[27:21]};
      job.vlq[1] = {1'b1, d[20:14]};
      job.vlq[2] = {1'b1, d[13:7]};
      job.vlq[3] = {1'b0, d[6:0]};
    end else if (d >= 28'd16384) begin
      job.vlq_cnt = 3'd3;
      job.vlq[0] = {1'b1, d[20:14]};
      job.vlq[1] = {1'b1, d[13:7]};
      job.vlq[2] = {1'b0, d[6:0]};
    end else if (d >= 28'd128) begin
      job.vlq_cnt = 3'd2;
      job.vlq[0] = {1'b1, d[13:7]};
      job.vlq[1] = {1'b0, d[6:0]};
    end else begin
      job.vlq_cnt = 3'd1;
      job.vlq[0] = {1'b0, d[6:0]};
    end

    chan_op = 1'b1;
    d2e = item.second_data;
    dcnt = 3'd2;
    status = {ST_NOTE_ON, item.channel};
    unique case (item.opcode)
      OP_NOTE_OFF: begin
        if (rs_r == {ST_NOTE_ON, item.channel} && item.second_data == relvel_r) begin
          d2e = '0;
        end else begin
          status = {ST_NOTE_OFF, item.channel};
        end
      end
      OP_NOTE_ON: status = {ST_NOTE_ON, item.channel};
      OP_PATCH: begin
        status = {ST_PATCH, item.channel};
        dcnt = 3'd1;
      end
      OP_CONTROL: status = {ST_CONTROL, item.channel};
      OP_BEND: begin
        status = {ST_BEND, item.channel};
        d2e = item.bend_amount[13:7];
      end
      default: chan_op = 1'b0;
    endcase
    dat[0] = {1'b0, (item.opcode == OP_BEND) ? item.bend_amount[6:0] : item.first_data};
    dat[1] = {1'b0, d2e};
    emit_status = chan_op && (rs_r != status);

    rs_nxt = rs_r;
    mask_nxt = mask_r;
    if (accept && chan_op) begin
      rs_nxt = status;
      mask_nxt = mask_r | (CHANNELS'(1) << item.channel);
    end

    if (emit_status) begin
      job.body[0] = status;
      job.body[1] = dat[0];
      job.body[2] = dat[1];
      job.body_cnt = dcnt + 3'd1;
    end else begin
      job.body[0] = dat[0];
      job.body[1] = dat[1];
      job.body_cnt = dcnt;
    end
    if (item.opcode == OP_TEMPO) begin
      job.body[0] = META_BYTE;
      job.body[1] = META_TEMPO;
      job.body[2] = 8'h03;
      job.body[3] = item.tempo_us[23:16];
      job.body[4] = item.tempo_us[15:8];
      job.body[5] = item.tempo_us[7:0];
      job.body_cnt = 3'd6;
    end else if (item.opcode == OP_END) begin
      job.body[0] = META_BYTE;
      job.body[1] = META_EOT;
      job.body[2] = 8'h00;
      job.body_cnt = 3'd3;
    end
    job.mask = mask_nxt;

    push = accept && (item.opcode <= OP_END);
    relvel_nxt = cfg_we ? cfg_wdata : relvel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= NO_STATUS;
      mask_r <= '0;
      relvel_r <= REL_VEL_RST;
    end else begin
      rs_r <= rs_nxt;
      mask_r <= mask_nxt;
      relvel_r <= relvel_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mevb_queue.sv @@
// Two-entry job queue between the front and back ends of the encoder.
// Uses mevb_pkg for the job type and the push and pop controls.
`default_nettype none
module mevb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mevb_pkg::q_ctl_t ctl,
  input  wire mevb_pkg::job_t wjob,
  output logic                full,
  output logic                nonempty,
  output mevb_pkg::job_t      head
);
  import mevb_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full = (cnt_r == 2'd2);
    nonempty = (cnt_r != 2'd0);
    head = mem_r[rp_r];
    wp_nxt = ctl.push ? ~wp_r : wp_r;
    rp_nxt = ctl.pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, ctl.push} - {1'b0, ctl.pop};
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wp_r] <= wjob;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mevb_back.sv @@
// Back end of the encoder: sends the queued job one byte per cycle while not
// stalled, through a registered output with valid and stall. Uses mevb_pkg.
`default_nettype none
module mevb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           nonempty,
  input  wire mevb_pkg::job_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mevb_pkg::out_item_t out_item
);
  import mevb_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  oi_r, oi_nxt;
  logic [3:0] total;
  logic [3:0] bidx;
  logic       load;
  logic       last;

  always_comb begin
    total = {1'b0, head.vlq_cnt} + {1'b0, head.body_cnt};
    bidx = idx_r - {1'b0, head.vlq_cnt};
    load = nonempty && (!ov_r || !out_stall);
    last = (idx_r == total - 4'd1);
    pop = load && last;
    idx_nxt = idx_r;
    ov_nxt = ov_r;
    oi_nxt = oi_r;
    if (load) begin
      ov_nxt = 1'b1;
      idx_nxt = last ? 4'd0 : idx_r + 4'd1;
      oi_nxt.out_byte = (idx_r < {1'b0, head.vlq_cnt}) ? head.vlq[idx_r[1:0]]
                                                     : head.body[bidx[2:0]];
      oi_nxt.last_byte = last;
      oi_nxt.used_channels = head.mask;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
    out_valid = ov_r;
    out_item = oi_r;
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    if (!rst_n) begin
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/midi_event_byte_encoder.sv @@
// MIDI event byte encoder: each accepted event item of opcode 0 to 6 gives 2
// to 10 Standard MIDI File bytes (10 for tempo with a four-byte delta), one
// result item per byte, with last_byte set on the final one; opcode 7 gives
// none. The output register delivers one byte per cycle while out_stall is
// low. A two-entry job queue sits between the front end, which tracks running
// status and the channel mask, and the byte sequencer, so a new event is
// taken whenever the queue has room. The release velocity register resets to
// 64 and is written through cfg_we and cfg_wdata.
`default_nettype none
module midi_event_byte_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mevb_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mevb_pkg::out_item_t      out_item
);
  import mevb_pkg::*;

  q_ctl_t ctl;
  job_t   wjob;
  job_t   head;
  logic   full;
  logic   nonempty;
  logic   accept;
  logic   push;
  logic   pop;

  assign in_stall = full;
  assign accept = in_valid && !full;
  assign ctl = '{push: push, pop: pop};

  mevb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .item     (in_item),
    .push     (push),
    .job      (wjob)
  );

  mevb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wjob    (wjob),
    .full    (full),
    .nonempty(nonempty),
    .head    (head)
  );

  mevb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

@@ rtl/mevb_checker.sv @@
// Port-level checker for the MIDI event byte encoder and its bind statement.
// Uses mevb_pkg for the result type.
`default_nettype none
module mevb_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mevb_pkg::out_item_t out_item
);
  import mevb_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed.");

  a_event_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_byte |=> out_valid)
    else $error("Event bytes were not sent back to back.");

  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid |->
      ((out_item.used_channels & $past(out_item.used_channels, 1))
       == $past(out_item.used_channels, 1)))
    else $error("Used channel mask lost a bit.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result item shown right after reset.");

endmodule

bind midi_event_byte_encoder mevb_checker u_mevb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
`default_nettype wire

@@ tb/tb_midi_event_byte_encoder.sv @@
// Self-checking testbench for midi_event_byte_encoder: drives event items, predicts the
// file bytes with running status and the release-velocity substitution, and checks each byte.
// Depends on rtl/mevb_pkg.sv and rtl/midi_event_byte_encoder.sv.
module tb_midi_event_byte_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mevb_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;

  out_item_t  expected_bytes[$];
  logic [6:0] release_vel;
  logic [7:0] running_st;
  logic [15:0] chan_mask;
  logic [3:0] last_on_ch;
  bit         tx_gaps;
  bit         rx_gaps;
  int         rx_hold;
  int         rx_wait;
  int         errors;

  midi_event_byte_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic encode_event(input in_item_t ev);
    logic [7:0] bytes[$];
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [6:0] part;
    bit         two_data;
    int         groups;
    out_item_t  r;
    if (ev.opcode > OP_END) return;
    if (ev.opcode <= OP_BEND) chan_mask[ev.channel] = 1'b1;
    groups = 1;
    if (ev.delta_ticks >= 28'd128) groups = 2;
    if (ev.delta_ticks >= 28'd16384) groups = 3;
    if (ev.delta_ticks >= 28'd2097152) groups = 4;
    for (int g = groups - 1; g >= 0; g--) begin
      part = 7'(ev.delta_ticks >> (7 * g));
      bytes.push_back({(g > 0), part});
    end
    d1 = {1'b0, ev.first_data};
    d2 = {1'b0, ev.second_data};
    two_data = 1'b1;
    status = 8'h00;
    case (ev.opcode)
      OP_NOTE_OFF: begin
        if (running_st == {ST_NOTE_ON, ev.channel} && ev.second_data == release_vel) begin
          status = {ST_NOTE_ON, ev.channel};
          d2 = 8'h00;
        end else begin
          status = {ST_NOTE_OFF, ev.channel};
        end
      end
      OP_NOTE_ON: status = {ST_NOTE_ON, ev.channel};
      OP_PATCH: begin
        status = {ST_PATCH, ev.channel};
        two_data = 1'b0;
      end
      OP_CONTROL: status = {ST_CONTROL, ev.channel};
      OP_BEND: begin
        status = {ST_BEND, ev.channel};
        d1 = {1'b0, ev.bend_amount[6:0]};
        d2 = {1'b0, ev.bend_amount[13:7]};
      end
      OP_TEMPO: begin
        bytes.push_back(META_BYTE);
        bytes.push_back(META_TEMPO);
        bytes.push_back(8'h03);
        bytes.push_back(ev.tempo_us[23:16]);
        bytes.push_back(ev.tempo_us[15:8]);
        bytes.push_back(ev.tempo_us[7:0]);
      end
      default: begin
        bytes.push_back(META_BYTE);
        bytes.push_back(META_EOT);
        bytes.push_back(8'h00);
      end
    endcase
    if (ev.opcode <= OP_BEND) begin
      if (running_st != status) begin
        bytes.push_back(status);
        running_st = status;
      end
      bytes.push_back(d1);
      if (two_data) bytes.push_back(d2);
    end
    for (int k = 0; k < bytes.size(); k++) begin
      r.out_byte      = bytes[k];
      r.last_byte     = (k == bytes.size() - 1);
      r.used_channels = chan_mask;
      expected_bytes.push_back(r);
    end
  endtask

  task automatic send_item(input in_item_t ev);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (in_stall);
    encode_event(ev);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_release(input logic [6:0] vel);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= vel;
    @(posedge clk);
    release_vel = vel;
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_event(input logic [2:0] op, input logic [27:0] delta,
                                          input logic [3:0] ch, input logic [6:0] d1,
                                          input logic [6:0] d2, input logic [13:0] bend,
                                          input logic [23:0] tempo);
    in_item_t ev;
    ev.opcode      = op;
    ev.delta_ticks = delta;
    ev.channel     = ch;
    ev.first_data  = d1;
    ev.second_data = d2;
    ev.bend_amount = bend;
    ev.tempo_us    = tempo;
    return ev;
  endfunction

  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    ev.delta_ticks = 28'($urandom);
    ev.channel     = 4'($urandom);
    ev.first_data  = 7'($urandom);
    ev.second_data = 7'($urandom);
    ev.bend_amount = 14'($urandom);
    ev.tempo_us    = 24'($urandom);
    case ($urandom_range(0, 3))
      0: ev.delta_ticks = 28'($urandom_range(0, 127));
      1: ev.delta_ticks = {14'd0, ev.delta_ticks[13:0]};
      2: ev.delta_ticks = {7'd0, ev.delta_ticks[20:0]};
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ev.opcode = OP_NOTE_ON;
      last_on_ch = ev.channel;
    end else if (pick < 60) begin
      ev.opcode = OP_NOTE_OFF;
      if ($urandom_range(0, 9) < 6) ev.channel = last_on_ch;
      if ($urandom_range(0, 9) < 6) ev.second_data = release_vel;
    end else if (pick < 68) begin
      ev.opcode = OP_PATCH;
    end else if (pick < 78) begin
      ev.opcode = OP_CONTROL;
    end else if (pick < 86) begin
      ev.opcode = OP_BEND;
    end else if (pick < 93) begin
      ev.opcode = OP_TEMPO;
    end else if (pick < 97) begin
      ev.opcode = OP_END;
    end else begin
      ev.opcode = OP_UNUSED;
    end
    return ev;
  endfunction

  task automatic test_directed();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_item(make_event(OP_NOTE_ON, 28'd0, 4'd0, 7'd60, 7'd100, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd0, 4'd0, 7'd60, 7'd64, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd1, 4'd0, 7'd60, 7'd10, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd2, 4'd0, 7'd61, 7'd64, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_ON, 28'd127, 4'd1, 7'd0, 7'd127, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd128, 4'd2, 7'd127, 7'd64, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_ON, 28'd3, 4'd3, 7'd40, 7'd90, 14'd0, 24'd0));
    send_item(make_event(OP_TEMPO, 28'd16383, 4'd0, 7'd0, 7'd0, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd16384, 4'd3, 7'd40, 7'd64, 14'd0, 24'd0));
    send_item(make_event(OP_PATCH, 28'd2097151, 4'd15, 7'd127, 7'd0, 14'd0, 24'd0));
    send_item(make_event(OP_PATCH, 28'd2097152, 4'd15, 7'd0, 7'd127, 14'd0, 24'd0));
    send_item(make_event(OP_CONTROL, 28'd0, 4'd15, 7'd0, 7'd127, 14'd0, 24'd0));
    send_item(make_event(OP_CONTROL, 28'd0, 4'd15, 7'd127, 7'd0, 14'd0, 24'd0));
    send_item(make_event(OP_BEND, 28'd5, 4'd7, 7'd0, 7'd0, 14'd0, 24'd0));
    send_item(make_event(OP_BEND, 28'd5, 4'd7, 7'd0, 7'd0, 14'h3FFF, 24'd0));
    send_item(make_event(OP_TEMPO, 28'hFFFFFFF, 4'd15, 7'd127, 7'd127, 14'h3FFF, 24'hFFFFFF));
    send_item(make_event(OP_UNUSED, 28'hFFFFFFF, 4'd15, 7'd127, 7'd127, 14'h3FFF,
                         24'hFFFFFF));
    send_item(make_event(OP_END, 28'd0, 4'd0, 7'd0, 7'd0, 14'd0, 24'd0));
  endtask

  task automatic test_release_velocity();
    write_release(7'd0);
    send_item(make_event(OP_NOTE_ON, 28'd0, 4'd5, 7'd70, 7'd1, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd9, 4'd5, 7'd70, 7'd0, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd9, 4'd5, 7'd71, 7'd0, 14'd0, 24'd0));
    write_release(7'd127);
    send_item(make_event(OP_NOTE_ON, 28'd0, 4'd9, 7'd36, 7'd127, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd0, 4'd9, 7'd36, 7'd127, 14'd0, 24'd0));
    send_item(make_event(OP_NOTE_OFF, 28'd0, 4'd9, 7'd36, 7'd64, 14'd0, 24'd0));
    write_release(7'd64);
  endtask

  task automatic test_random_traffic();
    in_item_t ev;
    int       sent;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) write_release(7'd0);
      else if (phase == 1) write_release(7'd127);
      else write_release(7'($urandom_range(0, 127)));
      tx_gaps = 1'($urandom_range(0, 1));
      rx_gaps = 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < 50) begin
        ev = random_event();
        send_item(ev);
        if (ev.opcode <= OP_END) sent++;
      end
    end
  endtask

  task automatic test_input_backpressure();
    wait_drain();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold = 200;
    for (int i = 0; i < 12; i++) begin
      send_item(make_event(OP_TEMPO, 28'hFFFFFFF - 28'(i), 4'(i), 7'(i), 7'(i), 14'(i),
                           24'($urandom)));
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        rx_wait = rx_gaps ? $urandom_range(0, 15) : 0;
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %0h", out_item.out_byte);
          errors++;
        end else begin
          out_item_t want;
          want = expected_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, out_item.last_byte);
            errors++;
          end
          if (out_item.used_channels !== want.used_channels) begin
            $error("used_channels: expected %0h, actual %0h", want.used_channels,
                   out_item.used_channels);
            errors++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5ms;
    $display("midi_event_byte_encoder regression: fail");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 7'd0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    release_vel = REL_VEL_RST;
    running_st  = NO_STATUS;
    chan_mask   = '0;
    last_on_ch  = 4'd0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    rx_hold     = 0;
    rx_wait     = 0;
    errors      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_release_velocity();
    test_input_backpressure();
    test_random_traffic();
    wait_drain();
    if (errors == 0) begin
      $display("midi_event_byte_encoder regression: pass");
    end else begin
      $display("midi_event_byte_encoder regression: fail");
    end
    $finish;
  end

endmodule
